// File: hdl/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types, codes and tables for the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

   typedef enum logic [1:0] {
      CMD_INSTR = 2'd0,
      CMD_CHAR  = 2'd1,
      CMD_GOTO  = 2'd2,
      CMD_INIT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PAUSE_NONE  = 2'd0,
      PAUSE_150US = 2'd1,
      PAUSE_5MS   = 2'd2,
      PAUSE_20MS  = 2'd3
   } pause_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_WAIT = 2'd1,
      BK_EMIT = 2'd2
   } back_state_type;

   // one byte transfer as queued between front and back
   typedef struct packed {
      logic      rs;
      logic [7:0] data;
      pause_type pause;
      logic      last;
   } xfer_type;

   // front to queue push
   typedef struct packed {
      logic     push;
      xfer_type xfer;
   } push_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam int unsigned STEP_W   = 4;
   localparam logic [STEP_W-1:0] INIT_LAST = 4'd8;

   localparam logic [7:0] FUNC_SET_8BIT = 8'h38;
   localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
   localparam logic [7:0] LCD_CLEAR     = 8'h01;
   localparam logic [7:0] LCD_HOME      = 8'h02;
   localparam logic [7:0] ENTRY_INC     = 8'h06;
   localparam logic [7:0] DISPLAY_ON    = 8'h0C;
   localparam logic [7:0] DDRAM_HOME    = 8'h80;

   function automatic logic [7:0] row_base(input logic [1:0] idx);
      logic [7:0] base;
      case (idx)
         2'd0:    base = 8'h80;
         2'd1:    base = 8'hC0;
         2'd2:    base = 8'h94;
         default: base = 8'hD4;
      endcase
      return base;
   endfunction

   function automatic xfer_type init_xfer(input logic [STEP_W-1:0] step,
                                          input logic four_bit);
      xfer_type x;
      x.rs    = 1'b0;
      x.data  = DDRAM_HOME;
      x.pause = PAUSE_NONE;
      x.last  = 1'b0;
      case (step)
         4'd0: begin
            x.data  = FUNC_SET_8BIT;
            x.pause = PAUSE_20MS;
         end
         4'd1: begin
            x.data  = FUNC_SET_8BIT;
            x.pause = PAUSE_5MS;
         end
         4'd2: begin
            x.data  = FUNC_SET_8BIT;
            x.pause = PAUSE_150US;
         end
         4'd3: x.data = LCD_CLEAR;
         4'd4: x.data = LCD_HOME;
         4'd5: x.data = ENTRY_INC;
         4'd6: x.data = DISPLAY_ON;
         4'd7: x.data = four_bit ? FUNC_SET_4BIT : FUNC_SET_8BIT;
         default: begin
            x.data = DDRAM_HOME;
            x.last = 1'b1;
         end
      endcase
      return x;
   endfunction

endpackage

// File: hdl/lcdw_front.sv
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts a request and expands it into byte transfers pushed into the queue.
// ----------------------------------------------------------------------------
module lcdw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_value,
   input  logic [2:0]             req_row,
   input  logic [7:0]             req_column,
   input  logic                   four_bit,
   input  lcdw_pkg::fifo_stat_type fifo_stat,
   output lcdw_pkg::push_type     push_out
);
   import lcdw_pkg::*;

   logic              active_ff, active_in;
   cmd_type           cmd_ff, cmd_in;
   logic [7:0]        value_ff, value_in;
   logic [7:0]        addr_ff, addr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              row_ok;
   logic              accept;
   xfer_type          xfer;
   logic              push;

   assign busy   = active_ff;
   assign accept = start && !active_ff;
   assign row_ok = (req_row != 3'd0) && (req_row <= 3'd4);

   always_comb begin
      unique case (cmd_ff)
         CMD_INSTR: xfer = '{rs: 1'b0, data: value_ff, pause: PAUSE_NONE, last: 1'b1};
         CMD_CHAR:  xfer = '{rs: 1'b1, data: value_ff, pause: PAUSE_NONE, last: 1'b1};
         CMD_GOTO: begin
            if (step_ff == '0) begin
               xfer = '{rs: 1'b0, data: addr_ff, pause: PAUSE_NONE, last: 1'b0};
            end else begin
               xfer = '{rs: 1'b1, data: value_ff, pause: PAUSE_NONE, last: 1'b1};
            end
         end
         CMD_INIT:  xfer = init_xfer(step_ff, four_bit);
      endcase
   end

   assign push = active_ff && !fifo_stat.full;
   assign push_out.push = push;
   assign push_out.xfer = xfer;

   always_comb begin
      active_in = active_ff;
      cmd_in    = cmd_ff;
      value_in  = value_ff;
      addr_in   = addr_ff;
      step_in   = step_ff;
      if (accept) begin
         active_in = 1'b1;
         cmd_in    = cmd_type'(req_command);
         value_in  = req_value;
         // row base plus column minus one, wrapping at 8 bits
         addr_in   = 8'(row_base(2'(req_row - 3'd1)) + req_column - 8'd1);
         step_in   = (cmd_type'(req_command) == CMD_GOTO && !row_ok) ? 4'd1 : 4'd0;
      end else if (push) begin
         if (xfer.last) begin
            active_in = 1'b0;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cmd_ff    <= CMD_INSTR;
      end else begin
         active_ff <= active_in;
         cmd_ff    <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      addr_ff  <= addr_in;
      step_ff  <= step_in;
   end

   a_accept_activates: assert property (@(posedge clock) disable iff (reset)
      accept |=> active_ff)
      else $error("front not active after accepted request");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      push && xfer.last |=> !active_ff)
      else $error("front still active after final transfer");

   a_init_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff && cmd_ff == CMD_INIT |-> step_ff <= INIT_LAST)
      else $error("init step out of range");

endmodule

// File: hdl/lcdw_fifo.sv
// ----------------------------------------------------------------------------
// lcdw_fifo
// Short transfer queue between the front and back of the sequencer.
// ----------------------------------------------------------------------------
module lcdw_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  lcdw_pkg::push_type      push_in,
   input  logic                    pop,
   output lcdw_pkg::xfer_type      head,
   output lcdw_pkg::fifo_stat_type stat
);
   import lcdw_pkg::*;

   xfer_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wptr_ff, wptr_in;
   logic [FIFO_AW-1:0]  rptr_ff, rptr_in;
   logic [FIFO_CW-1:0]  count_ff, count_in;

   assign stat.full  = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = push_in.push ? FIFO_AW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = pop ? FIFO_AW'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      case ({push_in.push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         mem_ff[wptr_ff] <= push_in.xfer;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> !stat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("queue count beyond depth");

endmodule

// File: hdl/lcdw_back.sv
// ----------------------------------------------------------------------------
// lcdw_back
// Times pauses and enable spacing, splits bytes into nibbles, emits strobes.
// ----------------------------------------------------------------------------
module lcdw_back #(
   parameter int unsigned TICKS_PER_US = 50
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    four_bit,
   input  lcdw_pkg::fifo_stat_type fifo_stat,
   input  lcdw_pkg::xfer_type      head,
   output logic                    pop,
   output logic                    rsp_strobe,
   output logic                    rsp_register_select,
   output logic [7:0]              rsp_bus_value,
   output logic [1:0]              rsp_pause_before,
   output logic                    rsp_last
);
   import lcdw_pkg::*;

   localparam int unsigned CNT_W = $clog2(20001 * TICKS_PER_US + 1);
   // wait before a strobe: the requested pause plus one microsecond of enable spacing
   localparam logic [CNT_W-1:0] GAP_NONE  = CNT_W'(TICKS_PER_US);
   localparam logic [CNT_W-1:0] GAP_150US = CNT_W'(151 * TICKS_PER_US);
   localparam logic [CNT_W-1:0] GAP_5MS   = CNT_W'(5001 * TICKS_PER_US);
   localparam logic [CNT_W-1:0] GAP_20MS  = CNT_W'(20001 * TICKS_PER_US);

   back_state_type   state_ff, state_in;
   xfer_type         cur_ff, cur_in;
   logic             low_ff, low_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] gap;

   always_comb begin
      case (head.pause)
         PAUSE_150US: gap = GAP_150US;
         PAUSE_5MS:   gap = GAP_5MS;
         PAUSE_20MS:  gap = GAP_20MS;
         default:     gap = GAP_NONE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!fifo_stat.empty) state_in = BK_WAIT;
         BK_WAIT: if (cnt_ff == '0) state_in = BK_EMIT;
         BK_EMIT: state_in = (four_bit && !low_ff) ? BK_WAIT : BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      cur_in = cur_ff;
      low_in = low_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_stat.empty) begin
               cur_in = head;
               low_in = 1'b0;
               cnt_in = gap;
            end
         end
         BK_WAIT: if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
         BK_EMIT: begin
            if (four_bit && !low_ff) begin
               low_in = 1'b1;
               cnt_in = GAP_NONE;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   // outputs
   always_comb begin
      pop                 = (state_ff == BK_IDLE) && !fifo_stat.empty;
      rsp_strobe          = (state_ff == BK_EMIT);
      rsp_register_select = cur_ff.rs;
      if (!four_bit) begin
         rsp_bus_value = cur_ff.data;
      end else if (low_ff) begin
         rsp_bus_value = {4'h0, cur_ff.data[3:0]};
      end else begin
         rsp_bus_value = {4'h0, cur_ff.data[7:4]};
      end
      rsp_pause_before = low_ff ? PAUSE_NONE : cur_ff.pause;
      rsp_last         = cur_ff.last && (!four_bit || low_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
   end

   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("strobes in adjacent cycles");

   a_high_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && four_bit && !low_ff |-> !rsp_last)
      else $error("high nibble marked last");

   a_nibble_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && four_bit |-> rsp_bus_value[7:4] == 4'h0)
      else $error("upper lines driven in four-bit mode");

   a_low_no_pause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && low_ff |-> rsp_pause_before == PAUSE_NONE)
      else $error("pause on low nibble");

endmodule

// File: hdl/char_lcd_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns LCD requests into enable-strobed bus transfers for a character LCD.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low: req_command selects
// instruction byte, character, positioned character or the init sequence.
// The front end holds busy while it expands the request into byte transfers;
// a four-entry queue feeds the back end, which waits the requested pause plus
// one microsecond of enable spacing before each strobe.
// Each transfer appears for one cycle on the rsp_ ports with rsp_strobe high;
// rsp_last marks the final one of a request. There is no hold-off on the
// result side. For each byte the back end fetches it from the queue, waits
// out the pause and spacing, then strobes; in four-bit mode it strobes the
// high nibble, waits the enable spacing alone and then strobes the low one.
// The front end keeps pushing bytes while the back end works, until the
// queue is full. The back end's spacing counter sets the rate. four_bit_bus
// sits at register address 0 of the APB port and must only be written while
// idle. Reset clears the queue, both state machines and four_bit_bus.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer #(
   parameter int unsigned TICKS_PER_US = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_value,
   input  logic [2:0]  req_row,
   input  logic [7:0]  req_column,
   output logic        rsp_strobe,
   output logic        rsp_register_select,
   output logic [7:0]  rsp_bus_value,
   output logic [1:0]  rsp_pause_before,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lcdw_pkg::*;

   logic          four_bit_ff, four_bit_in;
   logic          reg_hit;
   push_type      push;
   fifo_stat_type fifo_stat;
   xfer_type      head;
   logic          pop;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == 1'b0);
   assign prdata  = reg_hit ? {31'd0, four_bit_ff} : 32'd0;

   always_comb begin
      four_bit_in = four_bit_ff;
      if (psel && penable && pwrite && reg_hit) begin
         four_bit_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         four_bit_ff <= 1'b0;
      end else begin
         four_bit_ff <= four_bit_in;
      end
   end

   lcdw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_value   (req_value),
      .req_row     (req_row),
      .req_column  (req_column),
      .four_bit    (four_bit_ff),
      .fifo_stat   (fifo_stat),
      .push_out    (push)
   );

   lcdw_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .stat    (fifo_stat)
   );

   lcdw_back #(
      .TICKS_PER_US (TICKS_PER_US)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .four_bit            (four_bit_ff),
      .fifo_stat           (fifo_stat),
      .head                (head),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_register_select (rsp_register_select),
      .rsp_bus_value       (rsp_bus_value),
      .rsp_pause_before    (rsp_pause_before),
      .rsp_last            (rsp_last)
   );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character LCD write sequencer: drives
// instruction, character, positioned and init requests in both bus widths,
// predicts every strobed bus transfer and compares each one as it appears.
// ----------------------------------------------------------------------------
module tb_top;
   import lcdw_pkg::*;

   // one tick per microsecond keeps the millisecond init pauses short
   localparam int unsigned TB_TICKS_PER_US = 1;
   localparam int unsigned SETTLE_CYCLES   = 32;
   localparam logic [2:0]  ADDR_FOUR_BIT   = 3'd0;
   localparam logic [2:0]  ADDR_UNMAPPED   = 3'd4;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [7:0]  req_value;
   logic [2:0]  req_row;
   logic [7:0]  req_column;
   logic        rsp_strobe;
   logic        rsp_register_select;
   logic [7:0]  rsp_bus_value;
   logic [1:0]  rsp_pause_before;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   xfer_type expected_xfers[$];
   logic     bus_four_bit;
   int       sender_idle_pct;
   int       error_count;
   int       requests_sent;
   int       inits_sent;
   int       xfers_checked;

   char_lcd_write_sequencer #(
      .TICKS_PER_US(TB_TICKS_PER_US)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_value(req_value),
      .req_row(req_row),
      .req_column(req_column),
      .rsp_strobe(rsp_strobe),
      .rsp_register_select(rsp_register_select),
      .rsp_bus_value(rsp_bus_value),
      .rsp_pause_before(rsp_pause_before),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #200_000_000;
      $display("timeout at %0t with %0d transfers outstanding", $time,
               expected_xfers.size());
      $display("FAIL char_lcd_write_sequencer");
      $finish;
   end

   // ---------------------------------------------------------------------
   // transfer predictor
   // ---------------------------------------------------------------------
   task automatic expect_xfer(input logic rs, input logic [7:0] bus,
                              input pause_type pause, input logic is_last);
      xfer_type x;
      x.rs    = rs;
      x.data  = bus;
      x.pause = pause;
      x.last  = is_last;
      expected_xfers.push_back(x);
   endtask

   task automatic predict_transfers(input cmd_type cmd, input logic [7:0] val,
                                    input logic [2:0] row,
                                    input logic [7:0] col);
      logic [7:0] bytes [0:8];
      pause_type  pauses [0:8];
      logic       rs_of [0:8];
      logic [7:0] base;
      int         nb;
      nb = 0;
      for (int i = 0; i < 9; i++) begin
         pauses[i] = PAUSE_NONE;
         rs_of[i]  = 1'b0;
      end
      case (cmd)
         CMD_INSTR: begin
            bytes[0] = val;
            nb = 1;
         end
         CMD_CHAR: begin
            bytes[0] = val;
            rs_of[0] = 1'b1;
            nb = 1;
         end
         CMD_GOTO: begin
            if (row >= 3'd1 && row <= 3'd4) begin
               case (row)
                  3'd1:    base = 8'h80;
                  3'd2:    base = 8'hC0;
                  3'd3:    base = 8'h94;
                  default: base = 8'hD4;
               endcase
               // both the column offset and the sum wrap at 8 bits
               bytes[nb] = base + (col - 8'd1);
               nb++;
            end
            bytes[nb] = val;
            rs_of[nb] = 1'b1;
            nb++;
         end
         default: begin
            bytes[0] = 8'h38;  pauses[0] = PAUSE_20MS;
            bytes[1] = 8'h38;  pauses[1] = PAUSE_5MS;
            bytes[2] = 8'h38;  pauses[2] = PAUSE_150US;
            bytes[3] = 8'h01;
            bytes[4] = 8'h02;
            bytes[5] = 8'h06;
            bytes[6] = 8'h0C;
            bytes[7] = bus_four_bit ? 8'h28 : 8'h38;
            bytes[8] = 8'h80;
            nb = 9;
         end
      endcase
      for (int i = 0; i < nb; i++) begin
         if (bus_four_bit) begin
            // high nibble carries the pause, low nibble follows with no pause
            expect_xfer(rs_of[i], {4'h0, bytes[i][7:4]}, pauses[i], 1'b0);
            expect_xfer(rs_of[i], {4'h0, bytes[i][3:0]}, PAUSE_NONE, i == nb - 1);
         end else begin
            expect_xfer(rs_of[i], bytes[i], pauses[i], i == nb - 1);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // transfer checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      xfer_type exp_x;
      if (!reset && rsp_strobe) begin
         if (expected_xfers.size() == 0) begin
            $display("%0t: unexpected transfer rs=%0b bus=%02h pause=%0d last=%0b",
                     $time, rsp_register_select, rsp_bus_value, rsp_pause_before,
                     rsp_last);
            error_count++;
         end else begin
            exp_x = expected_xfers.pop_front();
            xfers_checked++;
            if (rsp_register_select !== exp_x.rs) begin
               $display("%0t: register_select expected %0b actual %0b", $time,
                        exp_x.rs, rsp_register_select);
               error_count++;
            end
            if (rsp_bus_value !== exp_x.data) begin
               $display("%0t: bus_value expected %02h actual %02h", $time,
                        exp_x.data, rsp_bus_value);
               error_count++;
            end
            if (rsp_pause_before !== exp_x.pause) begin
               $display("%0t: pause_before expected %0d actual %0d", $time,
                        exp_x.pause, rsp_pause_before);
               error_count++;
            end
            if (rsp_last !== exp_x.last) begin
               $display("%0t: last expected %0b actual %0b", $time, exp_x.last,
                        rsp_last);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // request driver and shared helpers
   // ---------------------------------------------------------------------
   task automatic send_request(input cmd_type cmd, input logic [7:0] val,
                               input logic [2:0] row, input logic [7:0] col);
      @(negedge clock);
      start       = 1'b1;
      req_command = cmd;
      req_value   = val;
      req_row     = row;
      req_column  = col;
      do @(posedge clock); while (busy);
      predict_transfers(cmd, val, row, col);
      requests_sent++;
      if (cmd == CMD_INIT) inits_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic release_start();
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_all_done();
      while (expected_xfers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_FOUR_BIT) bus_four_bit = data[0];
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_check(input logic [2:0] addr);
      logic [31:0] got;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = addr;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== {31'd0, bus_four_bit}) begin
         $display("%0t: four_bit_bus read expected %08h actual %08h", $time,
                  {31'd0, bus_four_bit}, got);
         error_count++;
      end
   endtask

   // move to a new bus width once everything in flight has come out
   task automatic set_bus_width(input logic four_bit);
      release_start();
      wait_all_done();
      csr_write(ADDR_FOUR_BIT, {31'($urandom_range(32'h7fff_ffff)), four_bit});
      csr_check(ADDR_FOUR_BIT);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_csr_access();
      csr_check(ADDR_FOUR_BIT);
      // no register behind this address, the width must not change
      csr_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
      csr_check(ADDR_FOUR_BIT);
      csr_write(ADDR_FOUR_BIT, 32'hFFFF_FFFF);
      csr_check(ADDR_FOUR_BIT);
      csr_write(ADDR_FOUR_BIT, 32'hFFFF_FFFE);
      csr_check(ADDR_FOUR_BIT);
   endtask

   task automatic test_eight_bit_directed();
      sender_idle_pct = 0;
      set_bus_width(1'b0);
      send_request(CMD_INSTR, 8'h00, 3'd7, 8'hFF);
      send_request(CMD_INSTR, 8'hFF, 3'd0, 8'h00);
      send_request(CMD_CHAR,  8'h00, 3'd2, 8'hFF);
      send_request(CMD_CHAR,  8'hFF, 3'd5, 8'h00);
      send_request(CMD_GOTO,  8'h41, 3'd1, 8'd1);
      // column 255 on row four overflows the address
      send_request(CMD_GOTO,  8'h42, 3'd4, 8'd255);
      // column zero wraps to 255 before the row base is added
      send_request(CMD_GOTO,  8'h43, 3'd2, 8'd0);
      send_request(CMD_GOTO,  8'h44, 3'd3, 8'd108);
      // rows outside one to four skip the cursor move
      send_request(CMD_GOTO,  8'h45, 3'd0, 8'd10);
      send_request(CMD_GOTO,  8'h46, 3'd5, 8'd10);
      send_request(CMD_GOTO,  8'h47, 3'd7, 8'd200);
      send_request(CMD_INIT,  8'hFF, 3'd7, 8'hFF);
   endtask

   task automatic test_four_bit_directed();
      sender_idle_pct = 7;
      set_bus_width(1'b1);
      send_request(CMD_INSTR, 8'hA5, 3'd3, 8'd3);
      send_request(CMD_CHAR,  8'h5A, 3'd4, 8'd4);
      send_request(CMD_GOTO,  8'hF0, 3'd4, 8'd200);
      send_request(CMD_GOTO,  8'h0F, 3'd6, 8'd1);
      send_request(CMD_INIT,  8'h00, 3'd0, 8'h00);
   endtask

   // pressure: each request waits until the previous one has fully drained
   task automatic test_one_at_a_time();
      sender_idle_pct = 0;
      for (int i = 0; i < 5; i++) begin
         send_request(CMD_GOTO, 8'($urandom_range(255)), 3'($urandom_range(1, 4)),
                      8'($urandom_range(255)));
         release_start();
         wait_all_done();
      end
   endtask

   task automatic test_random_phase(input logic four_bit, input int idle_pct,
                                    input int count);
      cmd_type    cmd;
      logic [2:0] row;
      logic [7:0] col;
      int         pick;
      set_bus_width(four_bit);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 25)      cmd = CMD_INSTR;
         else if (pick < 55) cmd = CMD_CHAR;
         else if (pick < 97) cmd = CMD_GOTO;
         else                cmd = CMD_INIT;
         if ($urandom_range(99) < 70) row = 3'($urandom_range(1, 4));
         else                         row = 3'($urandom_range(7));
         case ($urandom_range(9))
            0:       col = 8'd0;
            1:       col = 8'd1;
            2:       col = 8'd255;
            default: col = 8'($urandom_range(255));
         endcase
         send_request(cmd, 8'($urandom_range(255)), row, col);
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_command     = CMD_INSTR;
      req_value       = 8'h00;
      req_row         = 3'd0;
      req_column      = 8'h00;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = ADDR_FOUR_BIT;
      pwdata          = 32'd0;
      bus_four_bit    = 1'b0;
      sender_idle_pct = 0;
      error_count     = 0;
      requests_sent   = 0;
      inits_sent      = 0;
      xfers_checked   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_csr_access();
      test_eight_bit_directed();
      test_four_bit_directed();
      test_one_at_a_time();
      test_random_phase(1'b0, 0, 25);
      test_random_phase(1'b1, 0, 25);
      test_random_phase(1'b1, 85, 25);
      test_random_phase(1'b0, 85, 25);
      test_random_phase(1'b0, 7, 25);
      test_random_phase(1'b1, 7, 25);

      release_start();
      wait_all_done();
      $display("covered %0d requests (%0d init sequences) over both bus widths",
               requests_sent, inits_sent);
      $display("checked %0d strobed transfers, %0d mismatches", xfers_checked,
               error_count);
      if (error_count == 0 && expected_xfers.size() == 0) begin
         $display("PASS char_lcd_write_sequencer");
      end else begin
         $display("FAIL char_lcd_write_sequencer");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/lcdw_pkg.sv
hdl/lcdw_front.sv
hdl/lcdw_fifo.sv
hdl/lcdw_back.sv
hdl/char_lcd_write_sequencer.sv
test/tb_top.sv
